>>> src/amrbe_pkg.sv
package amrbe_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH         = 2;

  localparam logic [3:0] FT_NO_DATA = 4'd15;
  localparam logic [7:0] CMR_NONE   = 8'hF0;

  typedef enum logic [0:0] {
    CFG_WIDEBAND      = 1'b0,
    CFG_OCTET_ALIGNED = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic       end0;
    logic [7:0] byte1;
    logic       end1;
  } emit_t;

  function automatic logic [5:0] frame_len(input logic wb, input logic [3:0] ft);
    logic [5:0] len;
    len = 6'd0;
    if (wb) begin
      case (ft)
        4'd0: len = 6'd18;
        4'd1: len = 6'd24;
        4'd2: len = 6'd33;
        4'd3: len = 6'd37;
        4'd4: len = 6'd41;
        4'd5: len = 6'd47;
        4'd6: len = 6'd51;
        4'd7: len = 6'd59;
        4'd8: len = 6'd61;
        4'd9: len = 6'd7;
        default: len = 6'd0;
      endcase
    end else begin
      case (ft)
        4'd0: len = 6'd14;
        4'd1: len = 6'd15;
        4'd2: len = 6'd16;
        4'd3: len = 6'd18;
        4'd4: len = 6'd20;
        4'd5: len = 6'd22;
        4'd6: len = 6'd27;
        4'd7: len = 6'd32;
        4'd8: len = 6'd7;
        default: len = 6'd0;
      endcase
    end
    return len;
  endfunction

endpackage

>>> src/amrbe_if.sv
interface amrbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface amrbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_end;

  modport source (output valid, output payload_byte, output payload_end, input ready);
  modport sink (input valid, input payload_byte, input payload_end, output ready);
endinterface

>>> src/amr_octet_to_bandwidth_efficient_core.sv
// Channel   Dir  Payload                        Handshake
// in_if     in   data_byte[7:0], frame_end      valid/ready
// out_if    out  payload_byte[7:0], payload_end valid/ready
// cfg       in   cfg_idx_i, cfg_wdata_i         cfg_we_i, no stall
//
// Accepts one input item per cycle while the two-entry queue has room.
// Each item yields zero, one or two payload bytes; the output register
// sends one byte per cycle unless out_if.ready stalls it, byte0 then byte1.
// A byte passes through a queue entry and then the output register.
// Reset clears frame state, configuration, queue pointers and output valid.
// Output stalls fill the queue, then drop in_if.ready.
module amr_octet_to_bandwidth_efficient_core #(
  parameter int unsigned MAX_FRAME_BYTES = amrbe_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  amrbe_pkg::cfg_idx_e cfg_idx_i,
  input  logic                cfg_wdata_i,
  amrbe_in_if.sink            in_if,
  amrbe_out_if.source         out_if
);
  import amrbe_pkg::*;

  logic  push, full, q_valid, pop;
  emit_t push_ent, head_ent;

  amrbe_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .full_i     (full),
    .push_o     (push),
    .ent_o      (push_ent)
  );

  amrbe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ent_i  (push_ent),
    .full_o (full),
    .valid_o(q_valid),
    .ent_o  (head_ent),
    .pop_i  (pop)
  );

  amrbe_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(q_valid),
    .ent_i  (head_ent),
    .pop_o  (pop),
    .out_if (out_if)
  );

endmodule

>>> src/amrbe_front.sv
module amrbe_front #(
  parameter int unsigned MAX_FRAME_BYTES = amrbe_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  amrbe_pkg::cfg_idx_e cfg_idx_i,
  input  logic                cfg_wdata_i,
  amrbe_in_if.sink            in_if,
  input  logic                full_i,
  output logic                push_o,
  output amrbe_pkg::emit_t    ent_o
);
  import amrbe_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [7:0] MAX_BYTE = 8'(MAX_FRAME_BYTES);

  logic             wideband_q, octet_q;
  logic             in_frame_q, dropping_q;
  logic [1:0]       carry_q, carry_d;
  logic [CNT_W-1:0] sent_q, sent_d;
  logic [5:0]       limit_q, limit_d;
  logic             dropping_d;

  logic             in_acc;
  logic [7:0]       b;
  logic             fe;
  logic [3:0]       ft;
  logic [5:0]       tbl_len, new_len;

  logic             base_drop, drop1, drop2;
  logic [CNT_W-1:0] s0, s1, s_mid, s2, cap;
  logic [7:0]       p0_val, p1_val;
  logic             p0_last, p1_want, p1_last;
  logic             emit0, emit1, e0, e1;

  assign in_if.ready = !full_i;
  assign in_acc      = in_if.valid && in_if.ready;
  assign b           = in_if.data_byte;
  assign fe          = in_if.frame_end;
  assign ft          = b[6:3];
  assign tbl_len     = frame_len(wideband_q, ft);
  assign new_len     = (8'(tbl_len) > MAX_BYTE) ? MAX_BYTE[5:0] : tbl_len;

  always_comb begin
    s0        = sent_q;
    base_drop = dropping_q;
    limit_d   = limit_q;
    carry_d   = carry_q;
    p0_val    = b;
    p0_last   = fe;
    p1_want   = 1'b0;
    p1_val    = '0;
    p1_last   = 1'b1;
    if (!in_frame_q) begin
      s0      = '0;
      carry_d = {ft[0], b[2]};
      if (octet_q) begin
        limit_d   = '0;
        base_drop = (ft == FT_NO_DATA);
        p0_val    = CMR_NONE;
        p0_last   = 1'b0;
        p1_want   = 1'b1;
        p1_val    = b;
        p1_last   = fe;
      end else begin
        limit_d   = new_len;
        base_drop = (new_len == 6'd0);
        p0_val    = CMR_NONE | {4'b0000, b[7], ft[3:1]};
        p0_last   = 1'b0;
        p1_want   = fe;
        p1_val    = {ft[0], b[2], 6'b000000};
        p1_last   = 1'b1;
      end
    end else if (limit_q != 6'd0) begin
      p0_val  = {carry_q, b[7:2]};
      p0_last = 1'b0;
      carry_d = b[1:0];
      p1_want = fe;
      p1_val  = {b[1:0], 6'b000000};
      p1_last = 1'b1;
    end
  end

  always_comb begin
    cap   = (limit_d == 6'd0) ? MAX_CNT : CNT_W'(limit_d);
    emit0 = !base_drop;
    s1    = s0 + CNT_W'(1);
    e0    = p0_last || (s1 >= cap);
    drop1 = base_drop || (emit0 && e0 && !p0_last);
    s_mid = emit0 ? s1 : s0;
    emit1 = !drop1 && p1_want;
    s2    = s_mid + CNT_W'(1);
    e1    = p1_last || (s2 >= cap);
    drop2 = drop1 || (emit1 && e1 && !p1_last);
    sent_d     = emit1 ? s2 : s_mid;
    dropping_d = fe ? 1'b0 : drop2;
  end

  assign push_o      = in_acc && emit0;
  assign ent_o.two   = emit1;
  assign ent_o.byte0 = p0_val;
  assign ent_o.end0  = e0;
  assign ent_o.byte1 = p1_val;
  assign ent_o.end1  = e1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wideband_q <= 1'b0;
      octet_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDEBAND:      wideband_q <= cfg_wdata_i;
        CFG_OCTET_ALIGNED: octet_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      dropping_q <= 1'b0;
      carry_q    <= '0;
      sent_q     <= '0;
      limit_q    <= '0;
    end else if (in_acc) begin
      in_frame_q <= !fe;
      dropping_q <= dropping_d;
      carry_q    <= carry_d;
      sent_q     <= sent_d;
      limit_q    <= limit_d;
    end
  end

  a_first_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && ent_o.two |-> !ent_o.end0)
    else $error("first byte of a pair marked as payload end");

  a_frame_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && fe |-> (ent_o.two ? ent_o.end1 : ent_o.end0))
    else $error("frame end without payload end");

  a_idle_not_dropping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> !dropping_q)
    else $error("drop flag left set between frames");

  a_sent_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_q <= MAX_CNT)
    else $error("byte count beyond frame limit");

endmodule

>>> src/amrbe_queue.sv
module amrbe_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  amrbe_pkg::emit_t ent_i,
  output logic             full_o,
  output logic             valid_o,
  output amrbe_pkg::emit_t ent_o,
  input  logic             pop_i
);
  import amrbe_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  emit_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DEPTH_CNT);
  assign valid_o = (cnt_q != '0);
  assign ent_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> src/amrbe_back.sv
module amrbe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  amrbe_pkg::emit_t ent_i,
  output logic             pop_o,
  amrbe_out_if.source      out_if
);
  import amrbe_pkg::*;

  logic       sel_q, sel_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_end_q;
  logic       load;

  assign load  = valid_i && (!out_valid_q || out_if.ready);
  assign pop_o = load && (sel_q || !ent_i.two);

  always_comb begin
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    if (load) begin
      sel_d       = !sel_q && ent_i.two;
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= sel_q ? ent_i.byte1 : ent_i.byte0;
      out_end_q  <= sel_q ? ent_i.end1 : ent_i.end0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.payload_byte = out_byte_q;
  assign out_if.payload_end  = out_end_q;

endmodule

>>> tb/amr_octet_to_bandwidth_efficient_core_tb.sv
module amr_octet_to_bandwidth_efficient_core_tb;
  import amrbe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PAYLOAD_CAP = MAX_FRAME_BYTES_DEF;

  localparam logic [5:0] NB_LEN [16] = '{6'd14, 6'd15, 6'd16, 6'd18, 6'd20, 6'd22, 6'd27,
                                         6'd32, 6'd7, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
                                         6'd0, 6'd0};
  localparam logic [5:0] WB_LEN [16] = '{6'd18, 6'd24, 6'd33, 6'd37, 6'd41, 6'd47, 6'd51,
                                         6'd59, 6'd61, 6'd7, 6'd0, 6'd0, 6'd0, 6'd0,
                                         6'd0, 6'd0};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } frame_byte_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_end;
  } payload_t;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  cfg_idx_e cfg_idx_i;
  logic     cfg_wdata_i;

  amrbe_in_if  in_ch ();
  amrbe_out_if out_ch ();

  amr_octet_to_bandwidth_efficient_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  frame_byte_t frame_bytes_q[$];
  payload_t    payload_q[$];

  logic       cfg_wb;
  logic       cfg_oa;
  logic       pk_open;
  logic       pk_drop;
  logic [1:0] pk_carry;
  logic [6:0] pk_sent;
  logic [5:0] pk_limit;

  int errors;
  int items_pushed;
  int items_accepted;
  int frames_closed;
  int bytes_checked;
  int cycle_count;
  int src_gap_max;
  int sink_stall_lvl;
  int hold_asked;
  int hold_served;

  frame_byte_t cur_item;
  logic        drv_valid_next;
  int          burst_left;
  int          gap_left;

  logic [7:0] stall_pat;
  int         pat_pos;
  int         hold_left;
  logic       mon_ready_next;

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 30) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic emit_byte(input logic [7:0] v, input logic last);
    logic [6:0] cap;
    logic       fin;
    if (!pk_drop) begin
      cap = (pk_limit != 6'd0) ? {1'b0, pk_limit} : 7'(PAYLOAD_CAP);
      pk_sent++;
      fin = last || (pk_sent >= cap);
      payload_q.push_back('{v, fin});
      if (fin && !last) pk_drop = 1'b1;
    end
  endtask

  task automatic pack_item(input frame_byte_t it);
    logic [7:0] b;
    logic [3:0] ft;
    logic [5:0] len;
    logic       fe;
    b  = it.data_byte;
    fe = it.frame_end;
    if (!pk_open) begin
      ft       = b[6:3];
      pk_sent  = '0;
      pk_drop  = 1'b0;
      pk_carry = b[3:2];
      if (cfg_oa) begin
        pk_limit = '0;
        if (ft == FT_NO_DATA) begin
          pk_drop = 1'b1;
        end else begin
          emit_byte(CMR_NONE, 1'b0);
          emit_byte(b, fe);
        end
      end else begin
        len      = cfg_wb ? WB_LEN[ft] : NB_LEN[ft];
        pk_limit = len;
        if (len == 6'd0) begin
          pk_drop = 1'b1;
        end else begin
          emit_byte(CMR_NONE | {4'h0, b[7], ft[3:1]}, 1'b0);
          if (fe) emit_byte({pk_carry, 6'b0}, 1'b1);
        end
      end
      pk_open = !fe;
    end else begin
      if (pk_limit == 6'd0) begin
        emit_byte(b, fe);
      end else begin
        emit_byte({pk_carry, b[7:2]}, 1'b0);
        pk_carry = b[1:0];
        if (fe) emit_byte({pk_carry, 6'b0}, 1'b1);
      end
      if (fe) pk_open = 1'b0;
    end
    if (fe) pk_drop = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.frame_end <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pack_item(cur_item);
        items_accepted++;
        if (cur_item.frame_end) frames_closed++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        drv_valid_next = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
        drv_valid_next = 1'b0;
      end else if (frame_bytes_q.size() != 0) begin
        cur_item = frame_bytes_q.pop_front();
        drv_valid_next = 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = (src_gap_max != 0) ? $urandom_range(0, src_gap_max) : 0;
        end else begin
          burst_left--;
        end
      end else begin
        drv_valid_next = 1'b0;
      end
      in_ch.valid     <= drv_valid_next;
      in_ch.data_byte <= cur_item.data_byte;
      in_ch.frame_end <= cur_item.frame_end;
    end
  end

  task automatic check_payload(input logic [7:0] pb, input logic pe);
    payload_t want;
    bytes_checked++;
    if (payload_q.size() == 0) begin
      report_mismatch($sformatf("unexpected payload byte %02h end %0b", pb, pe));
    end else begin
      want = payload_q.pop_front();
      if (pb !== want.payload_byte)
        report_mismatch($sformatf("payload_byte %02h, want %02h", pb, want.payload_byte));
      if (pe !== want.payload_end)
        report_mismatch($sformatf("payload_end %0b, want %0b (byte %02h)", pe,
                                  want.payload_end, want.payload_byte));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_pat   = '0;
      pat_pos     = 0;
      hold_left   = 0;
      hold_served = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_payload(out_ch.payload_byte, out_ch.payload_end);
      if (hold_served != hold_asked) begin
        hold_left   = HOLD_CYCLES;
        hold_served = hold_asked;
      end
      if (pat_pos == 0) begin
        case (sink_stall_lvl)
          0:       stall_pat = '0;
          1:       stall_pat = 8'($urandom() & $urandom() & $urandom());
          default: stall_pat = 8'($urandom());
        endcase
      end
      mon_ready_next = (hold_left == 0) && !stall_pat[pat_pos];
      if (hold_left != 0) hold_left--;
      pat_pos = (pat_pos + 1) % 8;
      out_ch.ready <= mon_ready_next;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic fe);
    frame_bytes_q.push_back('{b, fe});
    items_pushed++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WIDEBAND) cfg_wb = v;
    else cfg_oa = v;
    @(negedge clk_i);
  endtask

  task automatic set_mode(input logic wb, input logic oa);
    write_reg(CFG_WIDEBAND, wb);
    write_reg(CFG_OCTET_ALIGNED, oa);
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (frame_bytes_q.size() != 0 || in_ch.valid || payload_q.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic add_random_frame();
    logic [3:0] ft;
    logic [7:0] toc;
    int         len;
    int         nsp;
    ft  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(0, cfg_wb ? 9 : 8));
    len = cfg_wb ? WB_LEN[ft] : NB_LEN[ft];
    if (len == 0) len = 8;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: nsp = $urandom_range(len - 3, len + 1);
      6, 7:             nsp = $urandom_range(0, 5);
      default:          nsp = cfg_oa ? $urandom_range(58, 66) : $urandom_range(0, len + 4);
    endcase
    toc = {1'($urandom()), ft, 1'($urandom()), 2'($urandom())};
    push_byte(toc, nsp == 0);
    for (int i = 1; i <= nsp; i++) push_byte(8'($urandom()), i == nsp);
  endtask

  task automatic random_frames(input int n_items);
    int start;
    start = items_pushed;
    while (items_pushed - start < n_items) add_random_frame();
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_WIDEBAND;
    cfg_wdata_i     = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.frame_end = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_wb          = 1'b0;
    cfg_oa          = 1'b0;
    pk_open         = 1'b0;
    pk_drop         = 1'b0;
    pk_carry        = '0;
    pk_sent         = '0;
    pk_limit        = '0;
    errors          = 0;
    items_pushed    = 0;
    items_accepted  = 0;
    frames_closed   = 0;
    bytes_checked   = 0;
    cycle_count     = 0;
    src_gap_max     = 3;
    sink_stall_lvl  = 1;
    hold_asked      = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // bandwidth-efficient, narrowband: single byte, no data, unlisted, cut, short
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h48, 1'b0);
    push_byte(8'hA5, 1'b1);
    push_byte(8'hC4, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h81, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(8'h3C, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h3D, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);
    drain();

    // octet-aligned: no data, unlisted type passed on, single byte
    set_mode(1'b0, 1'b1);
    push_byte(8'h7C, 1'b0);
    push_byte(8'h11, 1'b1);
    push_byte(8'h60, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h84, 1'b1);
    drain();

    set_mode(1'b0, 1'b0);
    random_frames(70);
    drain();

    // long output stall with the sender still offering items
    set_mode(1'b1, 1'b0);
    hold_asked++;
    random_frames(70);
    drain();

    // open a frame, then switch mode; the open frame keeps its old mode
    push_byte({1'b0, 4'd2, 1'b1, 2'b10}, 1'b0);
    push_byte(8'h9C, 1'b0);
    push_byte(8'h37, 1'b0);
    push_byte(8'hE1, 1'b0);
    drain();
    set_mode(1'b0, 1'b1);
    push_byte(8'h4B, 1'b0);
    push_byte(8'hD2, 1'b1);
    src_gap_max    = 0;
    sink_stall_lvl = 0;
    random_frames(70);
    drain();

    set_mode(1'b1, 1'b1);
    src_gap_max    = 6;
    sink_stall_lvl = 2;
    random_frames(70);
    drain();

    set_mode(1'b0, 1'b0);
    src_gap_max    = 2;
    sink_stall_lvl = 1;
    random_frames(70);
    drain();
    repeat (20) @(negedge clk_i);

    $display("run covered %0d input items in %0d frames, %0d payload bytes checked,",
             items_accepted, frames_closed, bytes_checked);
    $display("both length tables in both payload modes, with one long output stall");
    if (errors == 0 && payload_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d payload bytes never seen", errors, payload_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
